// ===== hdl/frame_rate_meter_assert.svh =====
// Assertion macros used by the checker of the frame rate meter.
`ifndef FRAME_RATE_METER_ASSERT_SVH
`define FRAME_RATE_METER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define FRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define FRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/frm_pkg.sv =====
// Shared types and constants of the frame rate meter.
package frm_pkg;

  // Field widths of the input and result words.
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned RATE_W     = 10;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned SCALED_W   = 56;
  localparam int unsigned PROD_W     = 48;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OUT_DATA_W = 256;
  localparam int unsigned OUT_PAD_W  =
    OUT_DATA_W - (STAMP_W + RATE_W + TIME_W + SCALED_W + TIME_W + SCALED_W);

  // Rate reported for a zero frame interval, and the dividend of 1000/delta.
  localparam logic [RATE_W-1:0] FPS_MAX = 10'd1000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE     = 2'd1;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] REFRESH_PERIOD_RST = 16'd500;
  localparam logic [CFG_W-1:0] TIME_SCALE_RST     = 16'd256;

  // Commands to the rate window.
  typedef struct packed {
    logic rd;   // read the entry at the head
    logic wr;   // replace the entry at the head, adjust the sum, advance
    logic clr;  // empty the window
  } win_cmd_t;

endpackage

// ===== hdl/frame_rate_meter.sv =====
// Frame rate meter top level: event sequencer, time counters and result register.
//
// Each input word is a frame tick or a level restart carrying a millisecond
// timestamp; every word yields exactly one result word. A frame tick passes
// through the states MUL, FDIV and UPD, then AVG when the refresh timer
// republishes the averaged rate, and FIN, where it enters the result register.
// The serial divider for 1000/delta runs in FDIV and delivers one of the
// RATE_W quotient bits per cycle. The average sum/WINDOW is taken as a
// multiplication by a constant reciprocal. A level restart goes from
// acceptance straight to FIN and on into the result register. One word is
// processed at a time. The next word is taken in the cycle after the result
// register is loaded, while that result may still wait there. A result that
// cannot be loaded because the previous one is stalled on the output holds
// the sequencer until the output frees. The window state is cleared at once
// by reset and by a restart, so no clearing pass is needed. Configuration
// writes are always accepted and must be issued while idle.
module frame_rate_meter #(
  parameter int unsigned WINDOW = 60
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input words
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [frm_pkg::STAMP_W-1:0]       in_tdata,   // [31:0] timestamp_ms
  input  logic [0:0]                        in_tuser,   // [0] op
  // Result words
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] delta_ms, [41:32] frame_rate, [89:42] game_ms, [145:90] game_scaled,
  // [193:146] level_ms, [249:194] level_scaled, [255:250] zero
  output logic [frm_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [frm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [frm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int unsigned SUM_W    = $clog2(WINDOW * int'(frm_pkg::FPS_MAX) + 1);
  localparam int unsigned STAMP_W  = frm_pkg::STAMP_W;
  localparam int unsigned RATE_W   = frm_pkg::RATE_W;
  localparam int unsigned TIME_W   = frm_pkg::TIME_W;
  localparam int unsigned SCALED_W = frm_pkg::SCALED_W;
  localparam int unsigned PROD_W   = frm_pkg::PROD_W;
  localparam int unsigned CFG_W    = frm_pkg::CFG_W;

  // Reciprocal of WINDOW, exact for every window sum that fits in SUM_W bits.
  localparam int unsigned RECIP_S = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned AVG_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_FDIV = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_AVG  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]                      state_r, state_nxt;
  logic [CFG_W-1:0]                period_r;
  logic [CFG_W-1:0]                scale_r;
  logic [STAMP_W-1:0]              last_r;
  logic [STAMP_W-1:0]              delta_r;
  logic [PROD_W-1:0]               prod_r;
  logic [RATE_W-1:0]               fps_r;
  logic [RATE_W-1:0]               shown_r;
  logic [STAMP_W-1:0]              timer_r;
  logic [TIME_W-1:0]               game_r;
  logic [SCALED_W-1:0]             gscl_r;
  logic [TIME_W-1:0]               level_r;
  logic [SCALED_W-1:0]             lscl_r;
  logic                            out_tvalid_r;
  logic [frm_pkg::OUT_DATA_W-1:0]  out_data_r;

  logic                            accept;
  logic                            restart;
  logic                            out_load;
  logic                            refresh;
  logic [STAMP_W:0]                timer_sum;
  logic [PROD_W-1:0]               prod_c;
  logic [AVG_W-1:0]                avg_prod;
  frm_pkg::win_cmd_t               win_cmd;
  logic [SUM_W-1:0]                win_sum;
  logic                            div_start;
  logic                            div_done;
  logic [RATE_W-1:0]               div_quotient;

  // Handshakes
  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign restart    = in_tuser[0];
  assign out_load   = (state_r == ST_FIN) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  // Window commands: read the oldest rate on a tick, replace it after the divide.
  always_comb begin
    win_cmd.rd  = accept && !restart;
    win_cmd.clr = accept && restart;
    win_cmd.wr  = (state_r == ST_UPD);
  end

  // The divider is started on 1000/delta in the same state that takes the scaled delta.
  assign div_start = (state_r == ST_MUL);

  // Refresh timer decision, saturating timer add, scaled delta and window average.
  always_comb begin
    refresh   = (timer_r >= STAMP_W'(period_r));
    timer_sum = {1'b0, timer_r} + {1'b0, delta_r};
    prod_c    = PROD_W'(delta_r) * PROD_W'(scale_r);
    avg_prod  = AVG_W'(win_sum) * AVG_W'(RECIP_M);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = restart ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_FDIV;
      ST_FDIV: begin
        if (div_done) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:  state_nxt = refresh ? ST_AVG : ST_FIN;
      ST_AVG:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer, configuration and the meter's persistent state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      period_r     <= frm_pkg::REFRESH_PERIOD_RST;
      scale_r      <= frm_pkg::TIME_SCALE_RST;
      last_r       <= '0;
      shown_r      <= '0;
      timer_r      <= '0;
      game_r       <= '0;
      gscl_r       <= '0;
      level_r      <= '0;
      lscl_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        unique case (cfg_index)
          frm_pkg::REG_REFRESH_PERIOD: period_r <= cfg_data;
          frm_pkg::REG_TIME_SCALE:     scale_r  <= cfg_data;
          default: ;
        endcase
      end

      // A restart clears the level clocks and the shown rate.
      if (accept) begin
        last_r <= in_tdata;
        if (restart) begin
          shown_r <= '0;
          level_r <= '0;
          lscl_r  <= '0;
        end
      end

      // Timer and elapsed-time clocks move once per frame tick.
      if (state_r == ST_UPD) begin
        if (refresh) begin
          timer_r <= '0;
        end else begin
          timer_r <= timer_sum[STAMP_W] ? '1 : timer_sum[STAMP_W-1:0];
        end
        game_r  <= game_r + TIME_W'(delta_r);
        level_r <= level_r + TIME_W'(delta_r);
        gscl_r  <= gscl_r + SCALED_W'(prod_r);
        lscl_r  <= lscl_r + SCALED_W'(prod_r);
      end

      // The updated window sum is averaged in the cycle after the write.
      if (state_r == ST_AVG) begin
        shown_r <= avg_prod[RECIP_S +: RATE_W];
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Per-word working values.
  always_ff @(posedge clk) begin
    if (accept) begin
      delta_r <= restart ? '0 : in_tdata - last_r;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_c;
    end
    if ((state_r == ST_FDIV) && div_done) begin
      fps_r <= (delta_r == '0) ? frm_pkg::FPS_MAX : div_quotient;
    end
    if (out_load) begin
      out_data_r <= {{frm_pkg::OUT_PAD_W{1'b0}}, lscl_r, level_r, gscl_r, game_r,
                     shown_r, delta_r};
    end
  end

  frm_div #(
    .DIVIDEND_W (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (frm_pkg::FPS_MAX),
    .divisor  (delta_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  frm_win #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (win_cmd),
    .wdata (fps_r),
    .sum   (win_sum)
  );

endmodule

// ===== hdl/frm_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module frm_div #(
  parameter int unsigned DIVIDEND_W = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [DIVIDEND_W-1:0]               dividend,
  input  logic [frm_pkg::STAMP_W-1:0]         divisor,
  output logic                                done,
  output logic [DIVIDEND_W-1:0]               quotient
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
  localparam int unsigned REM_W = frm_pkg::STAMP_W;

  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [REM_W-1:0]      dvs_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [REM_W:0]        trial;
  logic [REM_W:0]        diff;
  logic                  ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/frm_win.sv =====
// Ring of recent frame rates in a synchronous memory, with its running sum.
module frm_win #(
  parameter int unsigned WINDOW = 60,
  parameter int unsigned SUM_W  = $clog2(WINDOW * int'(frm_pkg::FPS_MAX) + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  frm_pkg::win_cmd_t             cmd,
  input  logic [frm_pkg::RATE_W-1:0]    wdata,
  output logic [SUM_W-1:0]              sum
);

  localparam int unsigned HEAD_W = $clog2(WINDOW);
  localparam int unsigned RATE_W = frm_pkg::RATE_W;

  logic [RATE_W-1:0] mem_r [WINDOW];
  logic [WINDOW-1:0] vld_r;
  logic [HEAD_W-1:0] head_r;
  logic [RATE_W-1:0] rdata_r;
  logic              rvld_r;
  logic [SUM_W-1:0]  sum_r;
  logic [RATE_W-1:0] old_rate;
  logic [SUM_W-1:0]  sum_nxt;

  // Window memory: one write and one registered read at the head.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[head_r] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem_r[head_r];
    end
  end

  // An entry never written since the last clear counts as zero.
  always_comb begin
    old_rate = rvld_r ? rdata_r : '0;
    sum_nxt  = sum_r - SUM_W'(old_rate) + SUM_W'(wdata);
  end

  // Valid bits, head pointer and running sum.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      vld_r  <= '0;
      head_r <= '0;
      sum_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (cmd.rd) begin
        rvld_r <= vld_r[head_r];
      end
      if (cmd.wr) begin
        vld_r[head_r] <= 1'b1;
        sum_r         <= sum_nxt;
        head_r        <= (head_r == HEAD_W'(WINDOW - 1)) ? '0 : head_r + 1'b1;
      end
    end
  end

  assign sum = sum_r;

endmodule

// ===== hdl/frm_checker.sv =====
// Port-level checks of the frame rate meter and their binding to the top level.
`include "frame_rate_meter_assert.svh"

module frm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [frm_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // A stalled result word keeps its contents.
  `FRM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // The published average never exceeds the saturated rate.
  `FRM_ASSERT(a_rate_range, out_tvalid |-> (out_tdata[41:32] <= frm_pkg::FPS_MAX), "frame rate above maximum")

  // Words are processed one at a time: no second word in the cycle after one.
  `FRM_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "input taken on consecutive cycles")

  // No result word is presented straight out of reset.
  `FRM_ASSERT(a_reset_empty, $past(!rst_n) |-> !out_tvalid, "result word valid after reset")

endmodule

bind frame_rate_meter frm_checker u_frm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/frame_rate_meter_tb.sv =====
// Self-checking testbench for the frame rate meter, predicting every result word.
module frame_rate_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW_LEN  = 60;
  localparam int unsigned IDLE_PCT    = 8;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYC  = 100;
  localparam int unsigned PHASE_ITEMS = 230;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_RESTART = 1'b1
  } meter_op_t;

  // Result fields, delta_ms in the lowest bits as on out_tdata.
  typedef struct packed {
    logic [frm_pkg::SCALED_W-1:0] level_scaled;
    logic [frm_pkg::TIME_W-1:0]   level_ms;
    logic [frm_pkg::SCALED_W-1:0] game_scaled;
    logic [frm_pkg::TIME_W-1:0]   game_ms;
    logic [frm_pkg::RATE_W-1:0]   frame_rate;
    logic [frm_pkg::STAMP_W-1:0]  delta_ms;
  } meter_result_t;

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [frm_pkg::STAMP_W-1:0]      in_tdata   = '0;   // [31:0] timestamp_ms
  logic [0:0]                       in_tuser   = '0;   // [0] op
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // delta, rate, game ms/scaled, level ms/scaled
  logic [frm_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [frm_pkg::CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [frm_pkg::CFG_W-1:0]        cfg_data   = '0;

  // Shadow copy of the meter state and its registers.
  logic [frm_pkg::CFG_W-1:0]        period_reg;
  logic [frm_pkg::CFG_W-1:0]        scale_reg;
  logic [frm_pkg::STAMP_W-1:0]      prev_stamp;
  logic [frm_pkg::RATE_W-1:0]       rate_ring [WINDOW_LEN];
  int unsigned                      ring_head;
  logic [15:0]                      ring_sum;
  logic [frm_pkg::STAMP_W-1:0]      refresh_count;
  logic [frm_pkg::RATE_W-1:0]       rate_shown;
  logic [frm_pkg::TIME_W-1:0]       game_acc;
  logic [frm_pkg::SCALED_W-1:0]     game_scaled_acc;
  logic [frm_pkg::TIME_W-1:0]       level_acc;
  logic [frm_pkg::SCALED_W-1:0]     level_scaled_acc;

  meter_result_t        meter_results_due[$];
  int unsigned          mismatches = 0;
  bit                   quiet      = 1'b0;

  frame_rate_meter #(
    .WINDOW(WINDOW_LEN)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void reset_meter_model();
    period_reg       = frm_pkg::REFRESH_PERIOD_RST;
    scale_reg        = frm_pkg::TIME_SCALE_RST;
    prev_stamp       = '0;
    foreach (rate_ring[i]) rate_ring[i] = '0;
    ring_head        = 0;
    ring_sum         = '0;
    refresh_count    = '0;
    rate_shown       = '0;
    game_acc         = '0;
    game_scaled_acc  = '0;
    level_acc        = '0;
    level_scaled_acc = '0;
  endfunction

  // Advance the shadow state by one input word and return the word it yields.
  function automatic meter_result_t predict_meter(input meter_op_t op,
                                                  input logic [frm_pkg::STAMP_W-1:0] stamp);
    meter_result_t               r;
    logic [frm_pkg::STAMP_W-1:0] delta;
    logic [frm_pkg::STAMP_W-1:0] fps;
    logic [frm_pkg::STAMP_W:0]   timer_sum;
    logic [frm_pkg::PROD_W-1:0]  scaled;
    if (op == OP_RESTART) begin
      foreach (rate_ring[i]) rate_ring[i] = '0;
      ring_head        = 0;
      ring_sum         = '0;
      rate_shown       = '0;
      level_acc        = '0;
      level_scaled_acc = '0;
      prev_stamp       = stamp;
      delta            = '0;
    end else begin
      delta      = stamp - prev_stamp;
      prev_stamp = stamp;
      fps        = (delta == 0) ? 32'd1000 : 32'd1000 / delta;

      // The newest rate replaces the oldest one in the ring.
      ring_sum            = ring_sum - rate_ring[ring_head] + fps[15:0];
      rate_ring[ring_head] = fps[frm_pkg::RATE_W-1:0];
      ring_head           = (ring_head == WINDOW_LEN - 1) ? 0 : ring_head + 1;

      // The timer saturates while counting up; once due it republishes.
      if (refresh_count < {16'd0, period_reg}) begin
        timer_sum     = {1'b0, refresh_count} + {1'b0, delta};
        refresh_count = timer_sum[frm_pkg::STAMP_W] ? '1
                                                    : timer_sum[frm_pkg::STAMP_W-1:0];
      end else begin
        refresh_count = '0;
        rate_shown    = frm_pkg::RATE_W'(ring_sum / WINDOW_LEN);
      end

      scaled           = {16'd0, delta} * {32'd0, scale_reg};
      game_acc         = game_acc + {16'd0, delta};
      game_scaled_acc  = game_scaled_acc + {8'd0, scaled};
      level_acc        = level_acc + {16'd0, delta};
      level_scaled_acc = level_scaled_acc + {8'd0, scaled};
    end
    r.delta_ms     = delta;
    r.frame_rate   = rate_shown;
    r.game_ms      = game_acc;
    r.game_scaled  = game_scaled_acc;
    r.level_ms     = level_acc;
    r.level_scaled = level_scaled_acc;
    return r;
  endfunction

  // Offer one word after an occasional idle gap, then predict its result.
  task automatic send_event(input meter_op_t op,
                            input logic [frm_pkg::STAMP_W-1:0] stamp);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= stamp;
    do @(posedge clk); while (!in_tready);
    meter_results_due.push_back(predict_meter(op, stamp));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (meter_results_due.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back; only called while the meter is idle.
  task automatic set_config(input logic [frm_pkg::CFG_W-1:0] period,
                            input logic [frm_pkg::CFG_W-1:0] scale);
    cfg_valid <= 1'b1;
    cfg_index <= frm_pkg::REG_REFRESH_PERIOD;
    cfg_data  <= period;
    do @(posedge clk); while (!cfg_ready);
    period_reg = period;
    cfg_index <= frm_pkg::REG_TIME_SCALE;
    cfg_data  <= scale;
    do @(posedge clk); while (!cfg_ready);
    scale_reg = scale;
    cfg_valid <= 1'b0;
  endtask

  // Rate extremes, zero and wrapping intervals, and a restart, at reset settings.
  task automatic test_directed_events();
    send_event(OP_TICK, 32'd0);
    send_event(OP_TICK, 32'd0);
    send_event(OP_TICK, 32'd1);
    send_event(OP_TICK, 32'd17);
    send_event(OP_TICK, 32'd1017);
    send_event(OP_TICK, 32'd2018);
    send_event(OP_TICK, 32'd1500);
    send_event(OP_TICK, 32'hFFFF_FFFF);
    send_event(OP_TICK, 32'h0000_0000);
    send_event(OP_TICK, 32'hAAAA_AAAA);
    send_event(OP_RESTART, 32'h5555_5555);
    send_event(OP_TICK, 32'h5555_5569);
  endtask

  // With no refresh period the averaged rate is republished continually.
  task automatic test_zero_period();
    wait_drained();
    set_config(16'd0, 16'd0);
    for (int i = 0; i < 6; i++) send_event(OP_TICK, prev_stamp + 32'd10 + i);
  endtask

  // A huge interval drives the refresh timer into saturation.
  task automatic test_refresh_saturation();
    wait_drained();
    set_config(16'hFFFF, 16'hFFFF);
    send_event(OP_RESTART, 32'd0);
    send_event(OP_TICK, 32'd60000);
    send_event(OP_TICK, 32'd60000 + 32'hFFFF_FF00);
    send_event(OP_TICK, prev_stamp + 32'd5);
    send_event(OP_TICK, prev_stamp + 32'd7);
  endtask

  // Mostly steady frame intervals, with wild stamps, repeats and restarts mixed in.
  task automatic test_random_traffic();
    logic [frm_pkg::CFG_W-1:0]   period;
    logic [frm_pkg::CFG_W-1:0]   scale;
    logic [frm_pkg::STAMP_W-1:0] stamp;
    int unsigned                 pick;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin period = 16'd16;    scale = 16'd256;   end
        1: begin period = 16'd0;     scale = 16'hFFFF;  end
        2: begin period = 16'hFFFF;  scale = 16'd0;     end
        default: begin
          period = 16'($urandom_range(400));
          scale  = 16'($urandom_range(16'hFFFF));
        end
      endcase
      wait_drained();
      set_config(period, scale);
      quiet = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          send_event(OP_RESTART, $urandom);
        end else begin
          if (pick < 60)      stamp = prev_stamp + $urandom_range(50, 1);
          else if (pick < 75) stamp = prev_stamp + $urandom_range(2000);
          else if (pick < 80) stamp = prev_stamp;
          else if (pick < 90) stamp = $urandom;
          else                stamp = prev_stamp - $urandom_range(100, 1);
          send_event(OP_TICK, stamp);
        end
      end
      quiet = 1'b0;
    end
  endtask

  // The result side stalls now and then, except during a quiet stretch.
  initial begin
    forever begin
      @(posedge clk);
      out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_result
    meter_result_t due;
    meter_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      if (meter_results_due.size() == 0) begin
        $error("result word with no prediction outstanding");
        mismatches++;
      end else begin
        due = meter_results_due.pop_front();
        got = out_tdata[$bits(meter_result_t)-1:0];
        check_field("delta_ms", due.delta_ms, got.delta_ms);
        check_field("frame_rate", due.frame_rate, got.frame_rate);
        check_field("game_ms", due.game_ms, got.game_ms);
        check_field("game_scaled", due.game_scaled, got.game_scaled);
        check_field("level_ms", due.level_ms, got.level_ms);
        check_field("level_scaled", due.level_scaled, got.level_scaled);
        check_field("pad", '0, out_tdata[frm_pkg::OUT_DATA_W-1:$bits(meter_result_t)]);
      end
    end
  end

  // Give up once no word has moved on any channel for too long.
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    reset_meter_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_events();
    test_zero_period();
    test_refresh_saturation();
    test_random_traffic();
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (meter_results_due.size() != 0) begin
      $error("%0d predicted result words never arrived", meter_results_due.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/frm_pkg.sv
hdl/frm_div.sv
hdl/frm_win.sv
hdl/frame_rate_meter.sv
hdl/frm_checker.sv
tb/frame_rate_meter_tb.sv
